// ===== hw/rtl/multi_motor_speed_pid_macros.svh =====
// Assertion macros for the checker of the motor speed loop.
`ifndef MULTI_MOTOR_SPEED_PID_MACROS_SVH
`define MULTI_MOTOR_SPEED_PID_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define MMSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define MMSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mmsp_pkg.sv =====
// Shared types, constants and log table builders for the motor speed loop.
package mmsp_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_INT_LIMIT = 3'd3,
        CFG_CUR_LIMIT = 3'd4
    } cfg_addr_t;

    localparam logic [15:0] GAIN_P_RESET    = 16'd3866;
    localparam logic [15:0] GAIN_I_RESET    = 16'd200;
    localparam logic [15:0] GAIN_D_RESET    = 16'd980;
    localparam logic [14:0] INT_LIMIT_RESET = 15'd15000;
    localparam logic [14:0] CUR_LIMIT_RESET = 15'd15000;

    // Number of registered stages from the input to the result register.
    localparam int PIPE_DEPTH = 8;

    // Errors up to this magnitude pass without compression.
    localparam logic [15:0] SMALL_ERR_MAX = 16'd200;
    // ln(2) in unsigned Q32.
    localparam logic [35:0] LN2_Q32 = 36'd2977044472;
    // 860 in Q12.4.
    localparam logic [16:0] LOG_OFFSET_Q4 = 17'd13760;

    // Shift-subtract division, used only while the tables are built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln(1 + m/256) in unsigned Q32 by the atanh series, every step truncated.
    function automatic logic [31:0] ln_frac_q32(input logic [7:0] m);
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] sq;
        y = udiv64({24'd0, m, 32'd0}, 64'd512 + {56'd0, m});
        sq = y * y;
        y2 = {32'd0, sq[63:32]};
        term = y;
        acc = '0;
        for (int k = 0; k < 16; k++) begin
            acc = acc + udiv64(term, 64'(2 * k + 1));
            sq = term * y2;
            term = {32'd0, sq[63:32]};
        end
        sq = acc << 1;
        return sq[31:0];
    endfunction

endpackage

// ===== hw/rtl/mmsp_err_shape.sv =====
// Three-stage error compression: leading-one split, log table lookup, scaling.
module mmsp_err_shape
    import mmsp_pkg::*;
(
    input  logic               aclk,
    input  logic [2:0]         stage_en,
    input  logic signed [16:0] err_in,
    output logic signed [15:0] err_q4
);

    logic [31:0] frac_rom [256];
    logic [35:0] ln2_rom  [16];

    for (genvar g = 0; g < 256; g++) begin : g_frac
        localparam logic [31:0] FRAC_VAL = ln_frac_q32(8'(g));
        assign frac_rom[g] = FRAC_VAL;
    end

    for (genvar g = 0; g < 16; g++) begin : g_ln2
        localparam logic [35:0] LN2_VAL = 36'(g) * LN2_Q32;
        assign ln2_rom[g] = LN2_VAL;
    end

    // Stage A: magnitude, leading-one position and the 8 bits below it.
    logic               neg_a_next, neg_a_reg;
    logic               big_a_next, big_a_reg;
    logic [3:0]         pos_a_next, pos_a_reg;
    logic [7:0]         man_a_next, man_a_reg;
    logic signed [15:0] small_a_next, small_a_reg;
    logic [15:0]        mag_a;
    logic [23:0]        shifted_a;

    always_comb begin
        neg_a_next = err_in[16];
        mag_a      = 16'(neg_a_next ? -err_in : err_in);
        big_a_next = mag_a > SMALL_ERR_MAX;
        pos_a_next = '0;
        for (int k = 0; k < 16; k++) begin
            if (mag_a[k]) begin
                pos_a_next = 4'(k);
            end
        end
        // Shifting mag*256 right by the position leaves the mantissa in the low byte.
        shifted_a    = {mag_a, 8'd0} >> pos_a_next;
        man_a_next   = shifted_a[7:0];
        small_a_next = 16'(err_in <<< 4);
    end

    // Stage B: ln|e| in unsigned Q32.
    logic               neg_b_reg, big_b_reg;
    logic signed [15:0] small_b_reg;
    logic [35:0]        ln_b_next, ln_b_reg;

    assign ln_b_next = ln2_rom[pos_a_reg] + {4'd0, frac_rom[man_a_reg]};

    // Stage C: round(3200 * ln) - 860*16, signed back on.
    logic [47:0]        scaled_c;
    logic [16:0]        comp_c;
    logic signed [15:0] err_c_next, err_c_reg;

    always_comb begin
        scaled_c = ({12'd0, ln_b_reg} << 11) + ({12'd0, ln_b_reg} << 10)
                 + ({12'd0, ln_b_reg} << 7) + 48'h0000_8000_0000;
        comp_c   = {1'b0, scaled_c[47:32]} - LOG_OFFSET_Q4;
        if (big_b_reg) begin
            err_c_next = neg_b_reg ? -$signed(comp_c[15:0]) : $signed(comp_c[15:0]);
        end else begin
            err_c_next = small_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            neg_a_reg   <= neg_a_next;
            big_a_reg   <= big_a_next;
            pos_a_reg   <= pos_a_next;
            man_a_reg   <= man_a_next;
            small_a_reg <= small_a_next;
        end
        if (stage_en[1]) begin
            neg_b_reg   <= neg_a_reg;
            big_b_reg   <= big_a_reg;
            small_b_reg <= small_a_reg;
            ln_b_reg    <= ln_b_next;
        end
        if (stage_en[2]) begin
            err_c_reg <= err_c_next;
        end
    end

    assign err_q4 = err_c_reg;

endmodule

// ===== hw/rtl/multi_motor_speed_pid.sv =====
// Top level of the four-motor positional PID speed loop.
// One request enters per clock cycle while s_ready is high; its result passes PIPE_DEPTH stages
// to the output register, and with m_ready held high the block sustains one update per cycle.
// Stage 1 forms the speed error, stages 2 to 4 compress large errors through the log table,
// stage 5 reads, clamps and writes back the per-motor error sum and last error in the same cycle,
// stage 6 forms the three gain products, stage 7 adds them and stage 8 applies the dead band
// and clamps and truncates the drive current. Each stage moves on when the one after it is
// empty or moving, so a stalled result does not stop requests from filling the bubbles behind it.
// Configuration writes are never stalled and should be made while no request is in flight.
module multi_motor_speed_pid
    import mmsp_pkg::*;
#(
    parameter int NUM_MOTORS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_motor_index,
    input  logic signed [15:0] s_target_speed,
    input  logic signed [15:0] s_measured_speed,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_motor_index_out,
    output logic signed [15:0] m_drive_current,
    output logic               m_integral_clamped,
    output logic               m_output_limited,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // Only four motors are addressable by the two-bit index.
    localparam int SLOTS  = (NUM_MOTORS < 4) ? NUM_MOTORS : 4;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Configuration registers.
    logic [15:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [14:0] int_limit_reg, cur_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= GAIN_P_RESET;
            gain_i_reg    <= GAIN_I_RESET;
            gain_d_reg    <= GAIN_D_RESET;
            int_limit_reg <= INT_LIMIT_RESET;
            cur_limit_reg <= CUR_LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GAIN_P:    gain_p_reg    <= cfg_data;
                CFG_GAIN_I:    gain_i_reg    <= cfg_data;
                CFG_GAIN_D:    gain_d_reg    <= cfg_data;
                CFG_INT_LIMIT: int_limit_reg <= cfg_data[14:0];
                CFG_CUR_LIMIT: cur_limit_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control.
    logic [PIPE_DEPTH:1] vld_reg, vld_next, go;

    always_comb begin
        go[PIPE_DEPTH] = !vld_reg[PIPE_DEPTH] || m_ready;
        for (int i = PIPE_DEPTH - 1; i >= 1; i--) begin
            go[i] = !vld_reg[i] || go[i + 1];
        end
        vld_next[1] = go[1] ? s_valid : vld_reg[1];
        for (int i = 2; i <= PIPE_DEPTH; i++) begin
            vld_next[i] = go[i] ? vld_reg[i - 1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = go[1];

    // Motor index and slot check ride alongside stages 1 to 4.
    logic [1:0] idx_pipe_reg [1:4];
    logic       ok_pipe_reg  [1:4];
    logic       ok_next;

    assign ok_next = {1'b0, s_motor_index} < 3'(SLOTS);

    always_ff @(posedge aclk) begin
        if (go[1]) begin
            idx_pipe_reg[1] <= s_motor_index;
            ok_pipe_reg[1]  <= ok_next;
        end
        for (int i = 2; i <= 4; i++) begin
            if (go[i]) begin
                idx_pipe_reg[i] <= idx_pipe_reg[i - 1];
                ok_pipe_reg[i]  <= ok_pipe_reg[i - 1];
            end
        end
    end

    // Stage 1: raw speed error.
    logic signed [16:0] err_s1_next, err_s1_reg;

    assign err_s1_next = 17'(s_target_speed) - 17'(s_measured_speed);

    always_ff @(posedge aclk) begin
        if (go[1]) begin
            err_s1_reg <= err_s1_next;
        end
    end

    // Stages 2 to 4: error compression.
    logic signed [15:0] err_s4;

    mmsp_err_shape u_err_shape (
        .aclk     (aclk),
        .stage_en (go[4:2]),
        .err_in   (err_s1_reg),
        .err_q4   (err_s4)
    );

    // Stage 5: per-motor error sum and previous error, read and written in the same cycle.
    logic signed [19:0] esum_reg [SLOTS];
    logic signed [15:0] prev_reg [SLOTS];
    logic [SLOT_W-1:0]  slot;
    logic signed [20:0] sum_raw, lim_i;
    logic signed [19:0] sum_next;
    logic               iclamp_next;
    logic signed [15:0] err_s5_next;
    logic signed [16:0] diff_next;

    assign slot = idx_pipe_reg[4][SLOT_W-1:0];

    always_comb begin
        lim_i       = $signed({2'b00, int_limit_reg, 4'd0});
        sum_raw     = 21'(esum_reg[slot]) + 21'(err_s4);
        sum_next    = 20'(sum_raw);
        iclamp_next = 1'b0;
        if (sum_raw > lim_i) begin
            sum_next    = 20'(lim_i);
            iclamp_next = 1'b1;
        end else if (sum_raw < -lim_i) begin
            sum_next    = 20'(-lim_i);
            iclamp_next = 1'b1;
        end
        err_s5_next = err_s4;
        diff_next   = 17'(err_s4) - 17'(prev_reg[slot]);
        // A motor index with no loop state yields a zero drive and no flags.
        if (!ok_pipe_reg[4]) begin
            sum_next    = '0;
            iclamp_next = 1'b0;
            err_s5_next = '0;
            diff_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                esum_reg[i] <= '0;
                prev_reg[i] <= '0;
            end
        end else if (go[5] && vld_reg[4] && ok_pipe_reg[4]) begin
            esum_reg[slot] <= sum_next;
            prev_reg[slot] <= err_s4;
        end
    end

    logic signed [15:0] err_s5_reg;
    logic signed [19:0] sum_s5_reg;
    logic signed [16:0] diff_s5_reg;
    logic               iclamp_s5_reg;
    logic [1:0]         idx_s5_reg;

    always_ff @(posedge aclk) begin
        if (go[5]) begin
            err_s5_reg    <= err_s5_next;
            sum_s5_reg    <= sum_next;
            diff_s5_reg   <= diff_next;
            iclamp_s5_reg <= iclamp_next;
            idx_s5_reg    <= idx_pipe_reg[4];
        end
    end

    // Stage 6: gain products, Q.12.
    logic signed [32:0] prod_p_next, prod_p_reg;
    logic signed [36:0] prod_i_next, prod_i_reg;
    logic signed [33:0] prod_d_next, prod_d_reg;
    logic               iclamp_s6_reg;
    logic [1:0]         idx_s6_reg;

    assign prod_p_next = $signed({1'b0, gain_p_reg}) * err_s5_reg;
    assign prod_i_next = $signed({1'b0, gain_i_reg}) * sum_s5_reg;
    assign prod_d_next = $signed({1'b0, gain_d_reg}) * diff_s5_reg;

    always_ff @(posedge aclk) begin
        if (go[6]) begin
            prod_p_reg    <= prod_p_next;
            prod_i_reg    <= prod_i_next;
            prod_d_reg    <= prod_d_next;
            iclamp_s6_reg <= iclamp_s5_reg;
            idx_s6_reg    <= idx_s5_reg;
        end
    end

    // Stage 7: sum of terms.
    logic signed [38:0] total_next, total_reg;
    logic               iclamp_s7_reg;
    logic [1:0]         idx_s7_reg;

    assign total_next = 39'(prod_p_reg) + 39'(prod_i_reg) + 39'(prod_d_reg);

    always_ff @(posedge aclk) begin
        if (go[7]) begin
            total_reg     <= total_next;
            iclamp_s7_reg <= iclamp_s6_reg;
            idx_s7_reg    <= idx_s6_reg;
        end
    end

    // Stage 8: dead band, current clamp and truncation toward zero.
    logic [38:0]        mag_s8;
    logic [38:0]        lim_o;
    logic signed [15:0] drive_next, drive_reg;
    logic               olim_next, olim_reg;
    logic               iclamp_s8_reg;
    logic [1:0]         idx_s8_reg;

    always_comb begin
        mag_s8     = total_reg[38] ? 39'(-total_reg) : 39'(total_reg);
        lim_o      = {12'd0, cur_limit_reg, 12'd0};
        drive_next = '0;
        olim_next  = 1'b0;
        if (mag_s8 < 39'd4096) begin
            drive_next = '0;
        end else if (mag_s8 > lim_o) begin
            drive_next = total_reg[38] ? -$signed({1'b0, cur_limit_reg})
                                       : $signed({1'b0, cur_limit_reg});
            olim_next  = 1'b1;
        end else begin
            drive_next = total_reg[38] ? -$signed({1'b0, mag_s8[26:12]})
                                       : $signed({1'b0, mag_s8[26:12]});
        end
    end

    always_ff @(posedge aclk) begin
        if (go[8]) begin
            drive_reg     <= drive_next;
            olim_reg      <= olim_next;
            iclamp_s8_reg <= iclamp_s7_reg;
            idx_s8_reg    <= idx_s7_reg;
        end
    end

    assign m_valid            = vld_reg[PIPE_DEPTH];
    assign m_motor_index_out  = idx_s8_reg;
    assign m_drive_current    = drive_reg;
    assign m_integral_clamped = iclamp_s8_reg;
    assign m_output_limited   = olim_reg;

endmodule

// ===== hw/rtl/mmsp_checker.sv =====
// Port-level checker for the motor speed loop and its bind to the top level.
`include "multi_motor_speed_pid_macros.svh"

module mmsp_checker
    import mmsp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_motor_index_out,
    input logic signed [15:0] m_drive_current
);

    // Requests accepted but not yet delivered.
    logic [4:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (s_valid && s_ready) begin
            count_next = count_next + 5'd1;
        end
        if (m_valid && m_ready) begin
            count_next = count_next - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    `MMSP_ASSERT_IMP(a_no_invented_result, m_valid, count_reg != 5'd0, "result without a request")
    `MMSP_ASSERT_IMP(a_in_flight_bound, 1'b1, count_reg <= 5'(PIPE_DEPTH), "too many in flight")
    `MMSP_ASSERT_IMP(a_drive_range, m_valid, m_drive_current != 16'sh8000, "drive out of range")
    `MMSP_ASSERT_NXT(a_result_held, m_valid && !m_ready,
                     m_valid && $stable(m_drive_current) && $stable(m_motor_index_out),
                     "stalled result changed")

endmodule

bind multi_motor_speed_pid mmsp_checker u_mmsp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_motor_index_out (m_motor_index_out),
    .m_drive_current   (m_drive_current)
);
